[hdl/tsl_pkg.sv]
// Shared constants and widths for the triangle slope limiter.
package tsl_pkg;

    // Fraction bits of the limiter value phi and of the value data.
    localparam int FRAC_BITS = 16;
    // Fraction bits of the beta register, fixed by its format.
    localparam int BETA_FRAC = 16;
    localparam int DAT_W     = 32;
    localparam int BETA_W    = 18;
    // Magnitude of a difference of two 32-bit values.
    localparam int MAG_W     = 32;
    localparam int PROD_W    = MAG_W + BETA_W;
    localparam int DEN_W     = MAG_W + BETA_FRAC;
    localparam int PHI_W     = FRAC_BITS + 1;
    localparam logic [PHI_W-1:0] PHI_ONE = PHI_W'(1) << FRAC_BITS;

    // Pipeline: input, product, divider steps, minimum, multiply, add, output.
    localparam int NUM_STAGES = FRAC_BITS + 6;

    localparam int S_TDATA_W = 296;
    localparam int M_TDATA_W = 256;

    // Configuration register indexes.
    localparam logic REG_LIMITER_BETA  = 1'b0;
    localparam logic REG_LIMIT_BY_EDGE = 1'b1;

endpackage

[hdl/tsl_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage.
module tsl_div_lane (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [tsl_pkg::DEN_W-1:0]      rem_in,
    input  logic [tsl_pkg::DEN_W-1:0]      den_in,
    output logic [tsl_pkg::FRAC_BITS-1:0]  q_out
);

    localparam int N = tsl_pkg::FRAC_BITS;
    localparam int W = tsl_pkg::DEN_W;

    logic [W-1:0] rem_reg  [N];
    logic [W-1:0] den_reg  [N];
    logic [N-1:0] q_reg    [N];
    logic [W-1:0] rem_next [N];
    logic [N-1:0] q_next   [N];

    // Each stage shifts the remainder and subtracts the divisor where it fits.
    always_comb begin
        logic [W-1:0] rp;
        logic [W-1:0] dp;
        logic [N-1:0] qp;
        logic [W:0]   sh;
        logic         ge;
        for (int k = 0; k < N; k++) begin
            rp = (k == 0) ? rem_in : rem_reg[(k == 0) ? 0 : k - 1];
            dp = (k == 0) ? den_in : den_reg[(k == 0) ? 0 : k - 1];
            qp = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k - 1];
            sh = {rp, 1'b0};
            ge = (sh >= {1'b0, dp});
            rem_next[k] = ge ? W'(sh - {1'b0, dp}) : sh[W-1:0];
            q_next[k]   = {qp[N-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                den_reg[k] <= (k == 0) ? den_in : den_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign q_out = q_reg[N-1];

endmodule

[hdl/triangle_slope_limiter.sv]
// Top level of the triangle slope limiter pipeline.
//
// Each item is one mesh triangle; the block returns one result item per
// triangle, in order. It takes one item per cycle while the output is not
// stalled. The three pipelined restoring dividers produce one quotient bit
// per stage. The whole pipeline advances together: while a result waits
// at the output and is not taken, the pipeline holds and s_tready is low.
// Configuration writes take effect for items accepted afterwards and
// should be made while the pipeline is empty.
module triangle_slope_limiter (
    input  logic                            aclk,
    input  logic                            aresetn,
    // centre_value, neighbour0_value, neighbour1_value, neighbour2_value,
    // neighbour_present, sample0_value, sample1_value, sample2_value,
    // slope_x_in, slope_y_in, zero fill
    input  logic [tsl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex0_out, vertex1_out, vertex2_out, edge0_out, edge1_out,
    // edge2_out, slope_x_out, slope_y_out
    output logic [tsl_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [tsl_pkg::BETA_W-1:0]      cfg_wdata
);

    localparam int DW  = tsl_pkg::DAT_W;
    localparam int MW  = tsl_pkg::MAG_W;
    localparam int FB  = tsl_pkg::FRAC_BITS;
    localparam int PW  = tsl_pkg::PHI_W;
    localparam int NS  = tsl_pkg::NUM_STAGES;
    localparam int ZCW = tsl_pkg::BETA_W + FB;

    // Side data carried alongside the divider lanes.
    typedef struct packed {
        logic signed [DW-1:0]  qc;
        logic [2:0]            neg;
        logic [2:0][MW-1:0]    dmag;
        logic [2:0]            forced;
        logic [2:0][PW-1:0]    fval;
        logic signed [DW-1:0]  sx;
        logic signed [DW-1:0]  sy;
        logic                  last;
        logic                  mode;
    } side_t;

    logic [tsl_pkg::BETA_W-1:0] beta_reg;
    logic                       mode_reg;
    logic [NS-1:0]              vld_reg;
    logic                       adv;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NS-1];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg <= tsl_pkg::BETA_W'(65536);
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tsl_pkg::REG_LIMITER_BETA:  beta_reg <= cfg_wdata;
                tsl_pkg::REG_LIMIT_BY_EDGE: mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    // Stage 1: bounds, differences and numerator magnitudes.
    logic signed [DW-1:0] in_qc, in_n [3], in_s [3];
    logic [2:0]           in_pres;
    logic signed [DW-1:0] qmin, qmax;
    logic signed [DW:0]   dq_w [3];
    logic signed [DW:0]   num_w [3];

    assign in_qc   = s_tdata[31:0];
    assign in_n[0] = s_tdata[63:32];
    assign in_n[1] = s_tdata[95:64];
    assign in_n[2] = s_tdata[127:96];
    assign in_pres = s_tdata[130:128];
    assign in_s[0] = s_tdata[162:131];
    assign in_s[1] = s_tdata[194:163];
    assign in_s[2] = s_tdata[226:195];

    always_comb begin
        qmin = in_qc;
        qmax = in_qc;
        for (int i = 0; i < 3; i++) begin
            if (in_pres[i] && in_n[i] < qmin) qmin = in_n[i];
            if (in_pres[i] && in_n[i] > qmax) qmax = in_n[i];
        end
        for (int i = 0; i < 3; i++) begin
            dq_w[i]  = {in_s[i][DW-1], in_s[i]} - {in_qc[DW-1], in_qc};
            num_w[i] = (dq_w[i] > 0) ? ({qmax[DW-1], qmax} - {in_qc[DW-1], in_qc})
                                     : ({qmin[DW-1], qmin} - {in_qc[DW-1], in_qc});
        end
    end

    logic signed [DW-1:0] p1_qc_reg, p1_sx_reg, p1_sy_reg;
    logic [2:0]           p1_neg_reg, p1_zero_reg;
    logic [MW-1:0]        p1_dmag_reg [3];
    logic [MW-1:0]        p1_nmag_reg [3];
    logic [tsl_pkg::BETA_W-1:0] p1_beta_reg;
    logic                 p1_last_reg, p1_mode_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_qc_reg   <= in_qc;
            p1_sx_reg   <= s_tdata[258:227];
            p1_sy_reg   <= s_tdata[290:259];
            p1_last_reg <= s_tlast;
            p1_mode_reg <= mode_reg;
            p1_beta_reg <= beta_reg;
            for (int i = 0; i < 3; i++) begin
                p1_neg_reg[i]  <= dq_w[i][DW];
                p1_zero_reg[i] <= (dq_w[i] == 0);
                p1_dmag_reg[i] <= dq_w[i][DW] ? MW'(-dq_w[i]) : MW'(dq_w[i]);
                p1_nmag_reg[i] <= num_w[i][DW] ? MW'(-num_w[i]) : MW'(num_w[i]);
            end
        end
    end

    // Stage 2: numerator times beta and the shifted divisor.
    logic signed [DW-1:0] p2_qc_reg, p2_sx_reg, p2_sy_reg;
    logic [2:0]           p2_neg_reg, p2_zero_reg;
    logic [MW-1:0]        p2_dmag_reg [3];
    logic [tsl_pkg::PROD_W-1:0] p2_rem_reg [3];
    logic [tsl_pkg::BETA_W-1:0] p2_beta_reg;
    logic                 p2_last_reg, p2_mode_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_qc_reg   <= p1_qc_reg;
            p2_sx_reg   <= p1_sx_reg;
            p2_sy_reg   <= p1_sy_reg;
            p2_last_reg <= p1_last_reg;
            p2_mode_reg <= p1_mode_reg;
            p2_beta_reg <= p1_beta_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_zero_reg <= p1_zero_reg;
            for (int i = 0; i < 3; i++) begin
                p2_dmag_reg[i] <= p1_dmag_reg[i];
                p2_rem_reg[i]  <= tsl_pkg::PROD_W'(p1_nmag_reg[i]) *
                                  tsl_pkg::PROD_W'(p1_beta_reg);
            end
        end
    end

    function automatic logic [ZCW-1:0] beta_zero_pad(input logic [tsl_pkg::BETA_W-1:0] b);
        beta_zero_pad = {b, {FB{1'b0}}};
    endfunction

    // Forced candidates: zero difference, or a ratio of one or more.
    logic [ZCW-1:0]            zc_w;
    logic [PW-1:0]             zc;
    logic [tsl_pkg::DEN_W-1:0] den [3];
    side_t                     side_next;

    always_comb begin
        zc_w = ({beta_zero_pad(p2_beta_reg)}) >> tsl_pkg::BETA_FRAC;
        zc   = (zc_w > ZCW'(tsl_pkg::PHI_ONE)) ? tsl_pkg::PHI_ONE : PW'(zc_w);
        side_next.qc   = p2_qc_reg;
        side_next.neg  = p2_neg_reg;
        side_next.sx   = p2_sx_reg;
        side_next.sy   = p2_sy_reg;
        side_next.last = p2_last_reg;
        side_next.mode = p2_mode_reg;
        for (int i = 0; i < 3; i++) begin
            den[i] = {p2_dmag_reg[i], {tsl_pkg::BETA_FRAC{1'b0}}};
            side_next.dmag[i]   = p2_dmag_reg[i];
            side_next.forced[i] = p2_zero_reg[i] ||
                                  (p2_rem_reg[i] >= tsl_pkg::PROD_W'(den[i]));
            side_next.fval[i]   = p2_zero_reg[i] ? zc : tsl_pkg::PHI_ONE;
        end
    end

    // Divider stages.
    side_t                   side_reg [FB];
    logic [FB-1:0]           q [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < FB; k++) begin
                side_reg[k] <= (k == 0) ? side_next : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        tsl_div_lane u_div (
            .aclk   (aclk),
            .en     (adv),
            .rem_in (tsl_pkg::DEN_W'(p2_rem_reg[g])),
            .den_in (den[g]),
            .q_out  (q[g])
        );
    end

    // Minimum stage: phi.
    side_t         sd;
    logic [PW-1:0] cand [3];
    logic [PW-1:0] phi_min;
    logic [PW-1:0] phi_reg;
    side_t         mn_reg;

    assign sd = side_reg[FB-1];

    always_comb begin
        phi_min = tsl_pkg::PHI_ONE;
        for (int i = 0; i < 3; i++) begin
            cand[i] = sd.forced[i] ? sd.fval[i] : {1'b0, q[i]};
            if (cand[i] < phi_min) phi_min = cand[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            phi_reg <= phi_min;
            mn_reg  <= sd;
        end
    end

    // Multiply stage: magnitudes times phi.
    logic [MW+PW-1:0] pv_reg [3];
    logic [MW+PW-1:0] px_reg, py_reg;
    logic             nx_reg, ny_reg;
    side_t            ml_reg;
    logic [MW-1:0]    sxm, sym;

    assign sxm = mn_reg.sx[DW-1] ? MW'(-mn_reg.sx) : MW'(mn_reg.sx);
    assign sym = mn_reg.sy[DW-1] ? MW'(-mn_reg.sy) : MW'(mn_reg.sy);

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                pv_reg[i] <= (MW+PW)'(mn_reg.dmag[i]) * (MW+PW)'(phi_reg);
            end
            px_reg <= (MW+PW)'(sxm) * (MW+PW)'(phi_reg);
            py_reg <= (MW+PW)'(sym) * (MW+PW)'(phi_reg);
            nx_reg <= mn_reg.sx[DW-1];
            ny_reg <= mn_reg.sy[DW-1];
            ml_reg <= mn_reg;
        end
    end

    // Add stage: limited samples with saturation, signed slopes.
    function automatic logic signed [DW-1:0] sat_w(input logic signed [DW+2:0] x);
        if (x > (DW+3)'(signed'(32'sh7FFFFFFF)))       sat_w = 32'sh7FFFFFFF;
        else if (x < (DW+3)'(signed'(32'sh80000000)))  sat_w = 32'sh80000000;
        else                                           sat_w = DW'(x);
    endfunction

    logic signed [DW-1:0] lim_reg [3];
    logic signed [DW-1:0] sxo_reg, syo_reg;
    logic                 ad_last_reg, ad_mode_reg;
    logic signed [DW+2:0] lsum [3];
    logic [MW:0]          mx, my;

    always_comb begin
        logic [MW:0] m;
        for (int i = 0; i < 3; i++) begin
            m = (MW+1)'(pv_reg[i] >> FB);
            lsum[i] = ml_reg.neg[i] ? ((DW+3)'(ml_reg.qc) - signed'((DW+3)'(m)))
                                    : ((DW+3)'(ml_reg.qc) + signed'((DW+3)'(m)));
        end
        mx = (MW+1)'(px_reg >> FB);
        my = (MW+1)'(py_reg >> FB);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) lim_reg[i] <= sat_w(lsum[i]);
            sxo_reg     <= nx_reg ? DW'(-mx) : DW'(mx);
            syo_reg     <= ny_reg ? DW'(-my) : DW'(my);
            ad_last_reg <= ml_reg.last;
            ad_mode_reg <= ml_reg.mode;
        end
    end

    // Output stage: derive the other set of values.
    logic signed [DW-1:0] v_o [3], e_o [3];
    logic signed [DW:0]   hs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hs[i] = (DW+1)'(lim_reg[(i+1)%3]) + (DW+1)'(lim_reg[(i+2)%3]);
            if (ad_mode_reg) begin
                e_o[i] = lim_reg[i];
                v_o[i] = sat_w((DW+3)'(lim_reg[(i+1)%3]) + (DW+3)'(lim_reg[(i+2)%3])
                               - (DW+3)'(lim_reg[i]));
            end else begin
                v_o[i] = lim_reg[i];
                e_o[i] = DW'(hs[i] >>> 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata <= {syo_reg, sxo_reg, e_o[2], e_o[1], e_o[0], v_o[2], v_o[1], v_o[0]};
            m_tlast <= ad_last_reg;
        end
    end

    // Checks on the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[FB+2] |-> (phi_reg <= tsl_pkg::PHI_ONE))
        else $error("phi above one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[FB+1] && sd.forced[0]) |->
        (sd.fval[0] <= tsl_pkg::PHI_ONE))
        else $error("forced candidate above one");

endmodule

[sim/triangle_slope_limiter_test.sv]
// Self-checking testbench for the triangle slope limiter stream pipeline.
module triangle_slope_limiter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = tsl_pkg::NUM_STAGES;
    localparam int CYCLE_LIMIT = 400000;

    // One triangle as offered on the input stream.
    typedef struct {
        logic signed [31:0] centre;
        logic signed [31:0] nbr [3];
        logic [2:0]         present;
        logic signed [31:0] sample [3];
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic               last;
    } triangle_t;

    // One limited triangle as returned on the output stream.
    typedef struct {
        logic signed [31:0] vtx [3];
        logic signed [31:0] edg [3];
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic               last;
    } limited_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [tsl_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tsl_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic                          cfg_index = tsl_pkg::REG_LIMITER_BETA;
    logic [tsl_pkg::BETA_W-1:0]    cfg_wdata = '0;

    triangle_slope_limiter dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor copy of the configuration registers.
    logic [17:0] beta_q16 = 18'd65536;
    logic        edge_mode = 1'b0;

    triangle_t pending_tris[$];
    limited_t  expected_results[$];
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    bit        sender_hold = 1'b0;
    int        mismatch_count = 0;
    int        results_seen = 0;
    longint    cycle_count = 0;

    function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Limiter candidate for one sample: min(num*beta/dq, 1) in Q.FRAC_BITS.
    function automatic logic [63:0] limiter_candidate(logic signed [63:0] num,
                                                      logic signed [63:0] diff);
        logic [63:0] unity;
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] quot;
        unity = 64'd1 << tsl_pkg::FRAC_BITS;
        if (diff == 0) begin
            quot = ({46'd0, beta_q16} << tsl_pkg::FRAC_BITS) >> tsl_pkg::BETA_FRAC;
            return (quot > unity) ? unity : quot;
        end
        numer = (num < 0 ? -num : num) * {46'd0, beta_q16};
        denom = (diff < 0 ? -diff : diff) << tsl_pkg::BETA_FRAC;
        if (numer >= denom) return unity;
        quot = '0;
        for (int i = 0; i < tsl_pkg::FRAC_BITS; i++) begin
            numer = numer << 1;
            quot = quot << 1;
            if (numer >= denom) begin
                numer = numer - denom;
                quot[0] = 1'b1;
            end
        end
        return quot;
    endfunction

    // Product by phi, rounded toward zero.
    function automatic logic signed [63:0] phi_scaled(logic [63:0] phi,
                                                      logic signed [63:0] d);
        logic [63:0] m;
        m = ((d < 0 ? -d : d) * phi) >> tsl_pkg::FRAC_BITS;
        return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] half_floor(logic signed [63:0] s);
        return s >>> 1;
    endfunction

    function automatic limited_t limit_triangle(triangle_t t);
        limited_t r;
        logic signed [63:0] qc, qmin, qmax;
        logic signed [63:0] diff [3];
        logic signed [63:0] lim [3];
        logic signed [63:0] v [3];
        logic signed [63:0] e [3];
        logic [63:0] phi, cand;
        qc = 64'(t.centre);
        qmin = qc;
        qmax = qc;
        phi = 64'd1 << tsl_pkg::FRAC_BITS;
        for (int i = 0; i < 3; i++)
            if (t.present[i]) begin
                if (64'(t.nbr[i]) < qmin) qmin = 64'(t.nbr[i]);
                if (64'(t.nbr[i]) > qmax) qmax = 64'(t.nbr[i]);
            end
        for (int i = 0; i < 3; i++) begin
            diff[i] = 64'(t.sample[i]) - qc;
            if (diff[i] > 0) cand = limiter_candidate(qmax - qc, diff[i]);
            else if (diff[i] < 0) cand = limiter_candidate(qmin - qc, diff[i]);
            else cand = limiter_candidate(64'sd0, 64'sd0);
            if (cand < phi) phi = cand;
        end
        for (int i = 0; i < 3; i++) lim[i] = clamp32(qc + phi_scaled(phi, diff[i]));
        if (edge_mode) begin
            for (int i = 0; i < 3; i++) e[i] = lim[i];
            v[0] = clamp32(e[1] + e[2] - e[0]);
            v[1] = clamp32(e[2] + e[0] - e[1]);
            v[2] = clamp32(e[0] + e[1] - e[2]);
        end else begin
            for (int i = 0; i < 3; i++) v[i] = lim[i];
            e[0] = half_floor(v[1] + v[2]);
            e[1] = half_floor(v[2] + v[0]);
            e[2] = half_floor(v[0] + v[1]);
        end
        for (int i = 0; i < 3; i++) begin
            r.vtx[i] = v[i][31:0];
            r.edg[i] = e[i][31:0];
        end
        r.gx = 32'(phi_scaled(phi, 64'(t.gx)));
        r.gy = 32'(phi_scaled(phi, 64'(t.gy)));
        r.last = t.last;
        return r;
    endfunction

    function automatic logic [tsl_pkg::S_TDATA_W-1:0] pack_triangle(triangle_t t);
        return tsl_pkg::S_TDATA_W'({t.gy, t.gx, t.sample[2], t.sample[1], t.sample[0],
                                    t.present, t.nbr[2], t.nbr[1], t.nbr[0], t.centre});
    endfunction

    // Driver: present the head of the pending queue, with random idle cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(limit_triangle(pending_tris.pop_front()));
            end
            if ((!s_tvalid || s_tready)) begin
                if (pending_tris.size() != 0 && !sender_hold
                    && $urandom_range(99) >= sender_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_triangle(pending_tris[0]);
                    s_tlast  <= pending_tris[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        limited_t want;
        logic signed [31:0] got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result with no triangle outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    for (int f = 0; f < 8; f++) begin
                        got = m_tdata[32*f +: 32];
                        case (f)
                            0, 1, 2: if (got !== want.vtx[f]) begin
                                $error("vertex%0d_out: expected %0d, got %0d", f,
                                       want.vtx[f], got);
                                mismatch_count++;
                            end
                            3, 4, 5: if (got !== want.edg[f-3]) begin
                                $error("edge%0d_out: expected %0d, got %0d", f-3,
                                       want.edg[f-3], got);
                                mismatch_count++;
                            end
                            6: if (got !== want.gx) begin
                                $error("slope_x_out: expected %0d, got %0d", want.gx, got);
                                mismatch_count++;
                            end
                            default: if (got !== want.gy) begin
                                $error("slope_y_out: expected %0d, got %0d", want.gy, got);
                                mismatch_count++;
                            end
                        endcase
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_cell_out: expected %0b, got %0b", want.last, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // Random triangle: neighbours and samples mostly close around the centre.
    function automatic triangle_t random_triangle();
        triangle_t t;
        logic signed [31:0] c;
        int span;
        span = 1 << $urandom_range(24);
        c = $signed($urandom_range(2 * span)) - span;
        t.centre = $urandom_range(9) == 0 ? random_value() : c;
        for (int i = 0; i < 3; i++) begin
            t.nbr[i] = $urandom_range(9) == 0 ? random_value()
                       : c + $signed($urandom_range(2 * span)) - span;
            t.sample[i] = $urandom_range(9) == 0 ? random_value()
                          : c + $signed($urandom_range(4 * span)) - 2 * span;
        end
        if ($urandom_range(7) == 0) t.sample[$urandom_range(2)] = t.centre;
        t.present = 3'($urandom);
        t.gx = $urandom_range(3) == 0 ? random_value() : $urandom;
        t.gy = $urandom_range(3) == 0 ? random_value() : $urandom;
        t.last = ($urandom_range(15) == 0);
        return t;
    endfunction

    function automatic triangle_t flat_triangle(logic signed [31:0] c,
                                                logic signed [31:0] s,
                                                logic [2:0] p);
        triangle_t t;
        t.centre = c;
        for (int i = 0; i < 3; i++) begin
            t.nbr[i] = c + (i + 1) * 32'sh10000 * (i == 1 ? -1 : 1);
            t.sample[i] = s + i;
        end
        t.present = p;
        t.gx = 32'sh7FFFFFFF;
        t.gy = 32'sh80000000;
        t.last = p[0];
        return t;
    endfunction

    task automatic drain();
        while (pending_tris.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [tsl_pkg::BETA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tsl_pkg::REG_LIMITER_BETA) beta_q16 = value;
        else edge_mode = value[0];
    endtask

    task automatic run_random(int n, int idle, int stall);
        sender_idle_pct = idle;
        receiver_stall_pct = stall;
        for (int i = 0; i < n; i++) pending_tris.push_back(random_triangle());
        drain();
    endtask

    initial begin
        triangle_t t;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, boundary masks, zero differences, both modes.
        for (int p = 0; p < 8; p++)
            pending_tris.push_back(flat_triangle(32'sh10000, 32'sh7FFFFFFF, p[2:0]));
        pending_tris.push_back(flat_triangle(32'sh80000000, 32'sh7FFFFFFF, 3'b111));
        pending_tris.push_back(flat_triangle(32'sh7FFFFFFF, 32'sh80000000, 3'b111));
        t = flat_triangle(32'sh0, 32'sh0, 3'b000);
        t.sample[1] = 0;
        t.sample[2] = 0;
        t.sample[0] = 0;
        pending_tris.push_back(t);
        drain();
        write_register(tsl_pkg::REG_LIMIT_BY_EDGE, 18'd1);
        for (int p = 0; p < 8; p += 3)
            pending_tris.push_back(flat_triangle(32'sh80000000, 32'sh7FFFFFF0, p[2:0]));
        drain();
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'h3FFFF);
        pending_tris.push_back(flat_triangle(32'sh0, 32'sh40000, 3'b111));
        pending_tris.push_back(flat_triangle(32'sh7FFFFFFF, 32'sh80000000, 3'b110));
        drain();
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'd0);
        pending_tris.push_back(flat_triangle(32'sh1234, 32'sh7FFF0000, 3'b111));
        pending_tris.push_back(flat_triangle(32'sh1234, 32'sh1234, 3'b111));
        drain();

        // Random phases across settings and idling patterns.
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'd131072);
        run_random(90, 0, 0);
        run_random(90, 56, 0);
        write_register(tsl_pkg::REG_LIMIT_BY_EDGE, 18'd0);
        run_random(90, 0, 56);
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'd65536);
        run_random(90, 38, 38);
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'($urandom_range(131072)));
        run_random(90, 0, 0);
        write_register(tsl_pkg::REG_LIMIT_BY_EDGE, 18'd1);
        run_random(90, 56, 0);
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'd32768);
        run_random(90, 0, 56);
        write_register(tsl_pkg::REG_LIMITER_BETA, 18'd1);
        run_random(70, 38, 38);

        $display("Covered %0d triangles in both limiting modes, beta from 0 to above 2.0,",
                 results_seen);
        $display("all neighbour masks and sender/receiver idling with full drains.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tsl_pkg.sv
hdl/tsl_div_lane.sv
hdl/triangle_slope_limiter.sv
sim/triangle_slope_limiter_test.sv
